### hw/rtl/sipq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
`default_nettype none
package sipq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ID_W      = 16;
  localparam int PRIO_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(2);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_REM_HEAD,
    S_REM,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/sipq_store.sv
// Entry store: one write port, one synchronous (registered) read port.
`default_nettype none
module sipq_store
  import sipq_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue.
//
// Input channel (in_valid / in_stall): one command per transfer. An insert
// carries entry_id and entry_priority; a remove takes the head entry.
// Output channel (out_valid / out_stall): exactly one result per command with
// status, the removed entry (zero unless a remove succeeded) and occupancy.
// Entries sit sorted by priority in a single-port-read memory, head at 0.
// An insert walks from the tail toward the head, one entry per cycle, moving
// each entry with a larger priority up one slot, then drops the new entry in.
// A remove reads the head, then moves every entry down one slot, one per cycle.
// A refused command goes straight to the last step; an insert first walks the
// queue from the tail and a remove reads the head, then walks the queue, each
// with one read and one write of the memory per cycle. One command is in work
// at a time; the next is taken the cycle after the result is loaded. The result
// register lets the next command start while a result waits; the block holds
// in its last step only if the previous result is still stalled. capacity_limit
// (cfg_write_en / cfg_write_data) must be written only while idle; the block
// does not enforce this. Reset (rst, synchronous) empties the queue and sets
// capacity to 16; the memory is not cleared since only written slots are used.
`default_nettype none
module sorted_insert_priority_queue
  import sipq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire logic [CAP_W-1:0]    cfg_write_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                command,
  input  wire logic [ID_W-1:0]     entry_id,
  input  wire logic [PRIO_W-1:0]   entry_priority,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [ID_W-1:0]          removed_id,
  output logic [PRIO_W-1:0]        removed_priority,
  output logic [OCC_W-1:0]         occupancy
);

  state_t              state, state_next;
  logic [CAP_W-1:0]    cap;
  logic [CNT_W-1:0]    cnt;          // count after the command in work
  logic [CNT_W-1:0]    p;            // slot being filled or just read
  entry_t              op_entry;     // entry carried by an insert
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [PRIO_W-1:0]   res_prio;

  mem_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic accept, out_free, full, empty, shift_up, rem_more, ins_last;
  logic [CMP_W-1:0] cap_eff;

  sipq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // saturate capacity at the physical depth
  assign cap_eff  = (CMP_W'(cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap);
  assign full     = CMP_W'(cnt) >= cap_eff;
  assign empty    = (cnt == '0);

  // tail-ward entry still belongs behind the new one: move it up
  assign shift_up = rd_data.prio > op_entry.prio;
  assign ins_last = (p == CNT_W'(1));
  // more entries to pull down while removing
  assign rem_more = p < cnt;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_INSERT) begin
            if (full)       state_next = S_FINISH;
            else if (empty) state_next = S_INS_PUT;
            else            state_next = S_INS;
          end else begin
            if (empty) state_next = S_FINISH;
            else       state_next = S_REM_HEAD;
          end
        end
      end
      S_INS: begin
        if (!shift_up)     state_next = S_FINISH;
        else if (ins_last) state_next = S_INS_PUT;
      end
      S_INS_PUT:  state_next = S_FINISH;
      S_REM_HEAD: state_next = (cnt != '0) ? S_REM : S_FINISH;
      S_REM:      state_next = rem_more ? S_REM : S_FINISH;
      S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    wr      = '0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && command == CMD_INSERT && !empty) begin
          rd_addr = IDX_W'(cnt - CNT_W'(1));
        end
      end
      S_INS: begin
        wr.en   = 1'b1;
        wr.addr = p[IDX_W-1:0];
        wr.data = shift_up ? rd_data : op_entry;
        rd_addr = IDX_W'(p - CNT_W'(2));
      end
      S_INS_PUT: begin
        wr.en   = 1'b1;
        wr.addr = p[IDX_W-1:0];
        wr.data = op_entry;
      end
      S_REM_HEAD: begin
        rd_addr = IDX_W'(1);
      end
      S_REM: begin
        wr.en   = 1'b1;
        wr.addr = IDX_W'(p - CNT_W'(1));
        wr.data = rd_data;
        rd_addr = IDX_W'(p + CNT_W'(1));
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        cap <= cfg_write_data;
      end
      if (accept) begin
        if (command == CMD_INSERT && !full) begin
          cnt <= cnt + CNT_W'(1);
        end else if (command == CMD_REMOVE && !empty) begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_entry.id   <= entry_id;
          op_entry.prio <= entry_priority;
          res_id        <= '0;
          res_prio      <= '0;
          p             <= (command == CMD_INSERT) ? cnt : '0;
          if (command == CMD_INSERT) begin
            res_status <= full ? ST_FULL : ST_DONE;
          end else begin
            res_status <= empty ? ST_EMPTY : ST_DONE;
          end
        end
      end
      S_INS: begin
        if (shift_up) begin
          p <= p - CNT_W'(1);
        end
      end
      S_REM_HEAD: begin
        res_id   <= rd_data.id;
        res_prio <= rd_data.prio;
        p        <= CNT_W'(1);
      end
      S_REM: begin
        p <= p + CNT_W'(1);
      end
      S_INS_PUT: begin
      end
      S_FINISH: begin
        if (out_free) begin
          status           <= res_status;
          removed_id       <= res_id;
          removed_priority <= res_prio;
          occupancy        <= OCC_W'(cnt);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
